// ===== src/ile_pkg.sv =====
package ile_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int CNT_W = 5;
	localparam int ST_W  = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	// what every cell does in the cycle of an accepted item
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_LOAD,
		OP_INS,
		OP_REM
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] tgt;
		logic [VAL_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== src/ile_if.sv =====
interface ile_req_if import ile_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, cmd, position, value, input ready);
	modport sink (input valid, cmd, position, value, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] read_value;
	logic [CNT_W-1:0]        entry_count;
	logic [ST_W-1:0]         status;

	modport source (output valid, read_value, entry_count, status, input ready);
	modport sink (input valid, read_value, entry_count, status, output ready);
endinterface

// ===== src/ile_cell.sv =====
module ile_cell import ile_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [VAL_W-1:0] left,
	input  logic [VAL_W-1:0] right,
	output logic [VAL_W-1:0] entry
);

	logic [VAL_W-1:0] entry_q;
	logic [VAL_W-1:0] entry_d;
	logic             en;

	always_comb begin
		entry_d = entry_q;
		en      = 1'b0;
		case (ctl.op)
			OP_LOAD: begin
				if (idx == ctl.tgt) begin
					entry_d = ctl.value;
					en      = 1'b1;
				end
			end
			OP_INS: begin
				// entries at and above the slot move up by one
				if (idx == ctl.tgt) begin
					entry_d = ctl.value;
					en      = 1'b1;
				end else if (idx > ctl.tgt) begin
					entry_d = left;
					en      = 1'b1;
				end
			end
			OP_REM: begin
				if (idx >= ctl.tgt) begin
					entry_d = right;
					en      = 1'b1;
				end
			end
			default: begin
				en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			entry_q <= entry_d;
		end
	end

	assign entry = entry_q;

endmodule

// ===== src/ile_ctrl.sv =====
module ile_ctrl import ile_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	ile_req_if.sink                     req,
	ile_rsp_if.source                   rsp,
	input  logic [DEPTH-1:0][VAL_W-1:0] entries,
	output cell_ctl_t                   ctl
);

	logic             rsp_valid_q;
	logic [VAL_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic [ST_W-1:0]  st_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             full;
	logic [CNT_W-1:0] count_d;
	logic [VAL_W-1:0] rd_d;
	logic [ST_W-1:0]  st_d;
	cell_op_t         op;
	logic [IDX_W-1:0] tgt;
	logic [IDX_W-1:0] pos_idx;

	// output register frees up whenever the receiver takes it
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign pos_idx   = req.position[IDX_W-1:0];

	always_comb begin
		count_d = count_q;
		rd_d    = '0;
		st_d    = ST_OK;
		op      = OP_HOLD;
		tgt     = pos_idx;
		case (req.cmd)
			CMD_APPEND: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					op      = OP_LOAD;
					tgt     = count_q[IDX_W-1:0];
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_INSERT: begin
				// range check comes before the full check
				if (req.position > count_q) begin
					st_d = ST_RANGE;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					op      = OP_INS;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (req.position >= count_q) begin
					st_d = ST_RANGE;
				end else begin
					op      = OP_REM;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (req.position >= count_q) begin
					st_d = ST_RANGE;
				end else begin
					rd_d = entries[pos_idx];
				end
			end
			CMD_WRITE: begin
				if (req.position >= count_q) begin
					st_d = ST_RANGE;
				end else begin
					op = OP_LOAD;
				end
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign ctl.op    = accept ? op : OP_HOLD;
	assign ctl.tgt   = tgt;
	assign ctl.value = req.value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (req.ready) begin
				rsp_valid_q <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q      <= rd_d;
			cnt_out_q <= count_d;
			st_q      <= st_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_value  = rd_q;
	assign rsp.entry_count = cnt_out_q;
	assign rsp.status      = st_q;

endmodule

// ===== src/indexed_list_engine_top.sv =====
// indexed list engine: an ordered list of up to 16 signed 32-bit entries
// req channel carries one command item (cmd, position, value); rsp channel
// returns one item per command with the entry read, the count after the
// command and a status (ok, index out of range, list full)
// commands: append, insert at index, remove at index, read, write, clear
// each entry lives in its own cell; insert and remove update the cells at and
// above the index in parallel, shifting from their neighbors
// the result is in the output register in the cycle after acceptance
// throughput: one item per cycle while not stalled, set by the single output
// register, which is refilled in the same cycle the receiver takes it
// when the receiver stalls, the result holds and req.ready drops until the
// result is taken
// reset clears the count and the output valid; entry contents are not
// cleared and are only readable once written below the count
module indexed_list_engine_top import ile_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	ile_req_if.sink   req,
	ile_rsp_if.source rsp
);

	cell_ctl_t                   ctl;
	logic [DEPTH-1:0][VAL_W-1:0] entries;

	ile_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.entries (entries),
		.ctl     (ctl)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] left;
		logic [VAL_W-1:0] right;

		// end cells never take from the missing neighbor
		if (i == 0) begin : g_first
			assign left = entries[i];
		end else begin : g_left
			assign left = entries[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = entries[i];
		end else begin : g_right
			assign right = entries[i+1];
		end

		ile_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx   (IDX_W'(i)),
			.left  (left),
			.right (right),
			.entry (entries[i])
		);
	end

endmodule

// ===== src/ile_checker.sv =====
module ile_checker import ile_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [VAL_W-1:0] read_value,
	input logic [CNT_W-1:0] entry_count,
	input logic [ST_W-1:0]  status
);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_FULL))
		else $error("undefined status code");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_value != '0 |-> status == ST_OK)
		else $error("nonzero read value on failed command");

	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted item gave no result next cycle");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value)
			&& $stable(entry_count) && $stable(status))
		else $error("stalled result changed");

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.read_value  (rsp.read_value),
	.entry_count (rsp.entry_count),
	.status      (rsp.status)
);

// ===== tb/tb_indexed_list_engine_top.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_engine_top import ile_pkg::*; ();

	// command codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	localparam int RANDOM_PER_PHASE = 670;
	localparam int LONG_HOLD        = 300;
	localparam int QUIET_LIMIT      = 4000;
	localparam int TAIL_CYCLES      = 10;

	typedef enum logic [1:0] {
		PH_RECV_SLOW,
		PH_SEND_SLOW,
		PH_STEADY
	} traffic_phase_t;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} list_cmd_t;

	typedef struct {
		logic signed [VAL_W-1:0] read_value;
		logic [CNT_W-1:0]        entry_count;
		logic [ST_W-1:0]         status;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ile_req_if req_ch ();
	ile_rsp_if rsp_ch ();

	indexed_list_engine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	list_cmd_t      cmd_queue[$];
	list_result_t   expected_results[$];
	traffic_phase_t phase;
	int             send_idle_pct;
	int             recv_idle_pct;

	// shadow copy of the list, updated as commands are accepted
	logic signed [VAL_W-1:0] shadow_entries [DEPTH];
	int                      shadow_len;

	// count tracked while generating, used to aim positions
	int gen_len;
	bit fill_mode;

	int queued_cnt;
	int accepted_cnt;
	int checked_cnt;
	int mismatch_cnt;
	int quiet_cycles = 0;
	int status_hits [3];
	int longest_list;

	int  hold_left;
	bit  long_hold_done;

	list_cmd_t    drive_item;
	list_cmd_t    seen_cmd;
	list_result_t want_res;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch on result %0d: %s", $realtime, checked_cnt, msg);
		mismatch_cnt++;
	endtask

	function automatic list_result_t apply_command(input list_cmd_t c);
		list_result_t res;
		int           p;
		p = c.position;
		res.read_value = '0;
		res.status = ST_OK;
		case (c.cmd)
			CMD_APPEND: begin
				if (shadow_len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_entries[shadow_len] = c.value;
					shadow_len++;
				end
			end
			CMD_INSERT: begin
				if (p > shadow_len) begin
					res.status = ST_RANGE;
				end else if (shadow_len >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (int i = shadow_len; i > p; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[p] = c.value;
					shadow_len++;
				end
			end
			CMD_REMOVE: begin
				if (p >= shadow_len) begin
					res.status = ST_RANGE;
				end else begin
					for (int i = p; i + 1 < shadow_len; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_len--;
				end
			end
			CMD_READ: begin
				if (p >= shadow_len)
					res.status = ST_RANGE;
				else
					res.read_value = shadow_entries[p];
			end
			CMD_WRITE: begin
				if (p >= shadow_len)
					res.status = ST_RANGE;
				else
					shadow_entries[p] = c.value;
			end
			CMD_CLEAR: begin
				shadow_len = 0;
			end
			default: begin
			end
		endcase
		res.entry_count = CNT_W'(shadow_len);
		status_hits[res.status]++;
		if (shadow_len > longest_list)
			longest_list = shadow_len;
		return res;
	endfunction

	task automatic push_cmd(input logic [CMD_W-1:0] c, input int p,
			input logic signed [VAL_W-1:0] v);
		list_cmd_t item;
		item.cmd = c;
		item.position = POS_W'(p);
		item.value = v;
		cmd_queue.push_back(item);
		queued_cnt++;
		case (c)
			CMD_APPEND: if (gen_len < DEPTH) gen_len++;
			CMD_INSERT: if (p <= gen_len && gen_len < DEPTH) gen_len++;
			CMD_REMOVE: if (p < gen_len) gen_len--;
			CMD_CLEAR:  gen_len = 0;
			default: begin
			end
		endcase
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_directed();
		push_cmd(CMD_READ, 0, 32'sd0);               // empty list, range
		push_cmd(CMD_REMOVE, 0, 32'sd0);
		push_cmd(CMD_WRITE, 31, -32'sd1);
		push_cmd(CMD_INSERT, 1, 32'sd7);             // past count
		push_cmd(CMD_INSERT, 0, 32'sh8000_0000);
		push_cmd(CMD_APPEND, 31, 32'sh7fff_ffff);
		push_cmd(CMD_INSERT, 2, -32'sd1);            // at count, acts as append
		push_cmd(CMD_INSERT, 1, 32'shaaaa_aaaa);
		push_cmd(CMD_READ, 1, 32'sd0);
		push_cmd(CMD_WRITE, 3, 32'sh5555_5555);
		push_cmd(CMD_READ, 3, 32'sd0);
		push_cmd(CMD_REMOVE, 0, 32'sd0);
		push_cmd(CMD_REMOVE, 2, 32'sd0);             // last entry
		push_cmd(CMD_READ, 31, 32'sd0);
		push_cmd(CMD_READ, 0, 32'sd0);
		push_cmd(CMD_SPARE6, 5, 32'sh1234_5678);
		push_cmd(CMD_SPARE7, 31, -32'sd1);
		push_cmd(CMD_CLEAR, 31, -32'sd1);
		push_cmd(CMD_READ, 0, 32'sd0);               // cleared entries stay hidden
	endtask

	task automatic add_random(input int n);
		int               r;
		int               p;
		int               lim;
		logic [CMD_W-1:0] op;
		for (int k = 0; k < n; k++) begin
			if (fill_mode && gen_len == DEPTH && $urandom_range(3) == 0)
				fill_mode = 1'b0;
			else if (!fill_mode && gen_len == 0)
				fill_mode = 1'b1;
			if ($urandom_range(99) < 4) begin
				push_cmd(CMD_W'($urandom_range(7)), $urandom_range(31), $urandom);
				continue;
			end
			r = $urandom_range(99);
			if (fill_mode) begin
				if (r < 35)      op = CMD_APPEND;
				else if (r < 65) op = CMD_INSERT;
				else if (r < 78) op = CMD_READ;
				else if (r < 88) op = CMD_WRITE;
				else if (r < 99) op = CMD_REMOVE;
				else             op = CMD_CLEAR;
			end else begin
				if (r < 40)      op = CMD_REMOVE;
				else if (r < 60) op = CMD_READ;
				else if (r < 75) op = CMD_WRITE;
				else if (r < 85) op = CMD_APPEND;
				else if (r < 97) op = CMD_INSERT;
				else             op = CMD_CLEAR;
			end
			// first position that is out of range for this op
			lim = (op == CMD_INSERT) ? gen_len + 1 : gen_len;
			if (op == CMD_APPEND || op == CMD_CLEAR)
				p = $urandom_range(31);
			else if (lim > 0 && $urandom_range(99) < 85)
				p = $urandom_range(lim - 1);
			else
				p = $urandom_range(31, lim);
			push_cmd(op, p, pick_value());
		end
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd <= '0;
			req_ch.position <= '0;
			req_ch.value <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				drive_item = cmd_queue.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.cmd <= drive_item.cmd;
				req_ch.position <= drive_item.position;
				req_ch.value <= drive_item.value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off at the start of the steady phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (phase == PH_STEADY && !long_hold_done) begin
			rsp_ch.ready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor: check results, then predict for the accepted command
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want_res = expected_results.pop_front();
					if (rsp_ch.read_value !== want_res.read_value)
						report_mismatch($sformatf("read_value %0d, expected %0d",
							rsp_ch.read_value, want_res.read_value));
					if (rsp_ch.entry_count !== want_res.entry_count)
						report_mismatch($sformatf("entry_count %0d, expected %0d",
							rsp_ch.entry_count, want_res.entry_count));
					if (rsp_ch.status !== want_res.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp_ch.status, want_res.status));
				end
				checked_cnt++;
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_cmd.cmd = req_ch.cmd;
				seen_cmd.position = req_ch.position;
				seen_cmd.value = req_ch.value;
				expected_results.push_back(apply_command(seen_cmd));
				accepted_cnt++;
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		shadow_len = 0;
		gen_len = 0;
		fill_mode = 1'b1;
		queued_cnt = 0;
		accepted_cnt = 0;
		checked_cnt = 0;
		mismatch_cnt = 0;
		longest_list = 0;
		status_hits = '{default: 0};
		phase = PH_RECV_SLOW;
		send_idle_pct = 18;
		recv_idle_pct = 79;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_directed();
		add_random(RANDOM_PER_PHASE);
		while (cmd_queue.size() > 0) @(negedge clk);

		phase = PH_SEND_SLOW;
		send_idle_pct = 79;
		recv_idle_pct = 18;
		add_random(RANDOM_PER_PHASE);
		while (cmd_queue.size() > 0) @(negedge clk);

		phase = PH_STEADY;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(RANDOM_PER_PHASE);

		while (accepted_cnt < queued_cnt || expected_results.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("ran %0d commands through three traffic mixes and one long output stall",
			accepted_cnt);
		$display("status ok %0d, out of range %0d, full %0d; longest list %0d of %0d",
			status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_FULL],
			longest_list, DEPTH);
		if (mismatch_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
